FILE: design/sbot_pkg.sv
// Shared constants and types of the swept box overlap time block.
package sbot_pkg;

   // Fraction bits of the contact time.
   localparam int FRAC_BITS = 16;

   // Field widths of the ports.
   localparam int CRD_W  = 32;
   localparam int HALF_W = 31;

   // Signed width of origin, motion, radius and slab numerators, and the
   // width of their magnitudes in the dividers.
   localparam int DIV_W = 37;

   // Quotient width, one bit per divider stage.
   localparam int Q_W        = FRAC_BITS + 1;
   localparam int DIV_STAGES = FRAC_BITS + 1;

   // Saturated slab times lie in [-1, ONE+1].
   localparam int TIME_W = FRAC_BITS + 3;
   localparam logic signed [TIME_W-1:0] TIME_ONE  = TIME_W'(longint'(1) << FRAC_BITS);
   localparam logic signed [TIME_W-1:0] TIME_SAT  = TIME_ONE + TIME_W'(1);
   localparam logic signed [TIME_W-1:0] TIME_NEG1 = '1;

   // Pipeline depth.
   localparam int PREP_STAGES = 3;
   localparam int RES_STAGES  = 2;
   localparam int LATENCY     = PREP_STAGES + DIV_STAGES + RES_STAGES;

   // One axis after setup: divider operands and the zero motion outcome.
   typedef struct packed {
      logic [DIV_W-1:0] mag_lo;
      logic [DIV_W-1:0] mag_hi;
      logic [DIV_W-1:0] mag_den;
      logic             neg_lo;
      logic             neg_hi;
      logic             still;
      logic             still_miss;
   } sbot_axis_type;

   // Zero motion flags of one axis, carried alongside the dividers.
   typedef struct packed {
      logic still;
      logic still_miss;
   } sbot_flag_type;

endpackage

FILE: design/sbot_prep.sv
// Three stage setup of one axis: relative values, slab numerators, magnitudes.
module sbot_prep (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [sbot_pkg::CRD_W-1:0]   mover_start,
   input  logic signed [sbot_pkg::CRD_W-1:0]   mover_end,
   input  logic        [sbot_pkg::HALF_W-1:0]  mover_half,
   input  logic signed [sbot_pkg::CRD_W-1:0]   target_start,
   input  logic signed [sbot_pkg::CRD_W-1:0]   target_end,
   input  logic        [sbot_pkg::HALF_W-1:0]  target_half,
   output sbot_pkg::sbot_axis_type             axis_o
);
   import sbot_pkg::*;

   logic signed [DIV_W-1:0] org_ff, org_in, mot_ff, mot_in, rad_ff, rad_in;
   logic signed [DIV_W-1:0] nlo_ff, nlo_in, nhi_ff, nhi_in, den_ff;
   logic                    still_ff, still_in, smiss_ff, smiss_in;
   sbot_axis_type           axis_ff, axis_in;

   always_comb begin
      org_in = DIV_W'(mover_start) - DIV_W'(target_start);
      mot_in = (DIV_W'(mover_end) - DIV_W'(mover_start))
             - (DIV_W'(target_end) - DIV_W'(target_start));
      rad_in = $signed(DIV_W'(mover_half)) + $signed(DIV_W'(target_half));
   end

   always_comb begin
      nlo_in   = -rad_ff - org_ff;
      nhi_in   = rad_ff - org_ff;
      still_in = (mot_ff == '0);
      smiss_in = (org_ff > rad_ff) || (org_ff < -rad_ff);
   end

   always_comb begin
      axis_in.mag_lo     = nlo_ff[DIV_W-1] ? DIV_W'(-nlo_ff) : DIV_W'(nlo_ff);
      axis_in.mag_hi     = nhi_ff[DIV_W-1] ? DIV_W'(-nhi_ff) : DIV_W'(nhi_ff);
      axis_in.mag_den    = den_ff[DIV_W-1] ? DIV_W'(-den_ff) : DIV_W'(den_ff);
      axis_in.neg_lo     = nlo_ff[DIV_W-1] ^ den_ff[DIV_W-1];
      axis_in.neg_hi     = nhi_ff[DIV_W-1] ^ den_ff[DIV_W-1];
      axis_in.still      = still_ff;
      axis_in.still_miss = smiss_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         org_ff   <= org_in;
         mot_ff   <= mot_in;
         rad_ff   <= rad_in;
         nlo_ff   <= nlo_in;
         nhi_ff   <= nhi_in;
         den_ff   <= mot_ff;
         still_ff <= still_in;
         smiss_ff <= smiss_in;
         axis_ff  <= axis_in;
      end
   end

   assign axis_o = axis_ff;

endmodule

FILE: design/sbot_div.sv
// Pipelined restoring divider, one quotient bit per stage, with time saturation.
module sbot_div (
   input  logic                              clock,
   input  logic                              en,
   input  logic [sbot_pkg::DIV_W-1:0]        num_mag,
   input  logic [sbot_pkg::DIV_W-1:0]        den_mag,
   input  logic                              neg,
   output logic signed [sbot_pkg::TIME_W-1:0] time_o
);
   import sbot_pkg::*;

   logic [DIV_W-1:0] rem_ff [DIV_STAGES];
   logic [DIV_W-1:0] den_ff [DIV_STAGES];
   logic [Q_W-1:0]   q_ff   [DIV_STAGES];
   logic             neg_ff [DIV_STAGES];
   logic             ovf_ff [DIV_STAGES];

   logic [DIV_W-1:0] rem0_in;
   logic [Q_W-1:0]   q0_in;
   logic             ovf0_in, bit0;

   // The quotient needs more than Q_W bits exactly when num >= 2 * den.
   always_comb begin
      ovf0_in = (num_mag >= {den_mag[DIV_W-2:0], 1'b0}) || den_mag[DIV_W-1];
      bit0    = (num_mag >= den_mag);
      rem0_in = bit0 ? (num_mag - den_mag) : num_mag;
      q0_in   = '0;
      q0_in[FRAC_BITS] = bit0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= rem0_in;
         den_ff[0] <= den_mag;
         q_ff[0]   <= q0_in;
         neg_ff[0] <= neg;
         ovf_ff[0] <= ovf0_in;
      end
   end

   for (genvar k = 1; k < DIV_STAGES; k++) begin : g_stage
      logic [DIV_W-1:0] shl, rem_in;
      logic [Q_W-1:0]   q_in;
      logic             bit_k;

      always_comb begin
         shl    = {rem_ff[k-1][DIV_W-2:0], 1'b0};
         bit_k  = (shl >= den_ff[k-1]);
         rem_in = bit_k ? (shl - den_ff[k-1]) : shl;
         q_in   = q_ff[k-1];
         q_in[FRAC_BITS-k] = bit_k;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_ff[k-1];
            q_ff[k]   <= q_in;
            neg_ff[k] <= neg_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   logic [Q_W-1:0] q_last;

   always_comb begin
      q_last = q_ff[DIV_STAGES-1];
      if (neg_ff[DIV_STAGES-1]) begin
         time_o = (ovf_ff[DIV_STAGES-1] || q_last != '0) ? TIME_NEG1 : '0;
      end else if (ovf_ff[DIV_STAGES-1] || $signed(TIME_W'(q_last)) > TIME_SAT) begin
         time_o = TIME_SAT;
      end else begin
         time_o = $signed(TIME_W'(q_last));
      end
   end

endmodule

FILE: design/sbot_resolve.sv
// Two stage resolve: order slab times, then narrow the enter and leave times.
module sbot_resolve (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [sbot_pkg::TIME_W-1:0]  lo_x,
   input  logic signed [sbot_pkg::TIME_W-1:0]  hi_x,
   input  logic signed [sbot_pkg::TIME_W-1:0]  lo_y,
   input  logic signed [sbot_pkg::TIME_W-1:0]  hi_y,
   input  sbot_pkg::sbot_flag_type             flag_x,
   input  sbot_pkg::sbot_flag_type             flag_y,
   output logic                                contact,
   output logic [sbot_pkg::FRAC_BITS:0]        contact_time
);
   import sbot_pkg::*;

   logic signed [TIME_W-1:0] ax_lo_ff, ax_hi_ff, ay_lo_ff, ay_hi_ff;
   sbot_flag_type            fx_ff, fy_ff;
   logic                     contact_ff, contact_in;
   logic [FRAC_BITS:0]       time_ff, time_in;

   always_ff @(posedge clock) begin
      if (en) begin
         ax_lo_ff <= (lo_x > hi_x) ? hi_x : lo_x;
         ax_hi_ff <= (lo_x > hi_x) ? lo_x : hi_x;
         ay_lo_ff <= (lo_y > hi_y) ? hi_y : lo_y;
         ay_hi_ff <= (lo_y > hi_y) ? lo_y : hi_y;
         fx_ff    <= flag_x;
         fy_ff    <= flag_y;
      end
   end

   logic signed [TIME_W-1:0] e1, l1, e2, l2;
   logic                     miss;

   always_comb begin
      miss = 1'b0;
      if (fx_ff.still) begin
         e1   = '0;
         l1   = TIME_ONE;
         miss = fx_ff.still_miss;
      end else begin
         e1   = (ax_lo_ff > 0) ? ax_lo_ff : '0;
         l1   = (ax_hi_ff < TIME_ONE) ? ax_hi_ff : TIME_ONE;
         miss = (e1 > l1);
      end
      if (fy_ff.still) begin
         e2   = e1;
         l2   = l1;
         miss = miss || fy_ff.still_miss;
      end else begin
         e2   = (ay_lo_ff > e1) ? ay_lo_ff : e1;
         l2   = (ay_hi_ff < l1) ? ay_hi_ff : l1;
         miss = miss || (e2 > l2);
      end
      contact_in = !miss;
      time_in    = miss ? '0 : e2[FRAC_BITS:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         contact_ff <= contact_in;
         time_ff    <= time_in;
      end
   end

   assign contact      = contact_ff;
   assign contact_time = time_ff;

endmodule

FILE: design/swept_box_overlap_time.sv
// Top level of the swept 2-D box overlap test with first contact time.
//
// Each request beat carries two boxes that move in a straight line over one
// time step, given as start centre, end centre and half-size in signed Q16.16.
// The response beat says whether they touch for some t in [0,1] and gives the
// earliest such t as unsigned Q1.16, where 65536 stands for t = 1 and a miss
// reports 0. The block takes one beat per cycle unless the response stalls
// and answers in request order through three setup stages (relative origin,
// motion and radius; slab numerators; magnitudes), seventeen divider stages
// that each resolve one quotient bit of the four slab divisions, and two
// resolve stages, the last of which is the response register. The whole
// pipeline advances together whenever the response register is empty or
// being emptied, so a stalled response holds every stage in place and
// request ready follows rsp_ready combinationally. The block keeps no state
// between pairs and has no configuration.
module swept_box_overlap_time (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [sbot_pkg::CRD_W-1:0]   req_mover_start_x,
   input  logic signed [sbot_pkg::CRD_W-1:0]   req_mover_start_y,
   input  logic signed [sbot_pkg::CRD_W-1:0]   req_mover_end_x,
   input  logic signed [sbot_pkg::CRD_W-1:0]   req_mover_end_y,
   input  logic        [sbot_pkg::HALF_W-1:0]  req_mover_half_x,
   input  logic        [sbot_pkg::HALF_W-1:0]  req_mover_half_y,
   input  logic signed [sbot_pkg::CRD_W-1:0]   req_target_start_x,
   input  logic signed [sbot_pkg::CRD_W-1:0]   req_target_start_y,
   input  logic signed [sbot_pkg::CRD_W-1:0]   req_target_end_x,
   input  logic signed [sbot_pkg::CRD_W-1:0]   req_target_end_y,
   input  logic        [sbot_pkg::HALF_W-1:0]  req_target_half_x,
   input  logic        [sbot_pkg::HALF_W-1:0]  req_target_half_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_contact,
   output logic [sbot_pkg::FRAC_BITS:0]        rsp_contact_time
);
   import sbot_pkg::*;

   // One valid bit per stage travels with the data.
   logic [LATENCY-1:0] valid_ff, valid_in;
   logic               advance;

   // The pipeline moves when the response register can take a new beat.
   assign advance   = !valid_ff[LATENCY-1] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = valid_ff[LATENCY-1];

   always_comb begin
      valid_in = {valid_ff[LATENCY-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // Setup of both axes.
   sbot_axis_type axis_x, axis_y;

   sbot_prep u_prep_x (
      .clock        (clock),
      .en           (advance),
      .mover_start  (req_mover_start_x),
      .mover_end    (req_mover_end_x),
      .mover_half   (req_mover_half_x),
      .target_start (req_target_start_x),
      .target_end   (req_target_end_x),
      .target_half  (req_target_half_x),
      .axis_o       (axis_x)
   );

   sbot_prep u_prep_y (
      .clock        (clock),
      .en           (advance),
      .mover_start  (req_mover_start_y),
      .mover_end    (req_mover_end_y),
      .mover_half   (req_mover_half_y),
      .target_start (req_target_start_y),
      .target_end   (req_target_end_y),
      .target_half  (req_target_half_y),
      .axis_o       (axis_y)
   );

   // Four slab divisions run side by side; their results are only used on
   // axes with nonzero relative motion.
   logic signed [TIME_W-1:0] lo_x, hi_x, lo_y, hi_y;

   sbot_div u_div_lo_x (
      .clock (clock), .en (advance),
      .num_mag (axis_x.mag_lo), .den_mag (axis_x.mag_den), .neg (axis_x.neg_lo),
      .time_o (lo_x)
   );

   sbot_div u_div_hi_x (
      .clock (clock), .en (advance),
      .num_mag (axis_x.mag_hi), .den_mag (axis_x.mag_den), .neg (axis_x.neg_hi),
      .time_o (hi_x)
   );

   sbot_div u_div_lo_y (
      .clock (clock), .en (advance),
      .num_mag (axis_y.mag_lo), .den_mag (axis_y.mag_den), .neg (axis_y.neg_lo),
      .time_o (lo_y)
   );

   sbot_div u_div_hi_y (
      .clock (clock), .en (advance),
      .num_mag (axis_y.mag_hi), .den_mag (axis_y.mag_den), .neg (axis_y.neg_hi),
      .time_o (hi_y)
   );

   // Zero motion flags are delayed to line up with the divider outputs.
   sbot_flag_type flag_x_ff [DIV_STAGES];
   sbot_flag_type flag_y_ff [DIV_STAGES];

   always_ff @(posedge clock) begin
      if (advance) begin
         flag_x_ff[0] <= '{still: axis_x.still, still_miss: axis_x.still_miss};
         flag_y_ff[0] <= '{still: axis_y.still, still_miss: axis_y.still_miss};
         for (int k = 1; k < DIV_STAGES; k++) begin
            flag_x_ff[k] <= flag_x_ff[k-1];
            flag_y_ff[k] <= flag_y_ff[k-1];
         end
      end
   end

   sbot_resolve u_resolve (
      .clock        (clock),
      .en           (advance),
      .lo_x         (lo_x),
      .hi_x         (hi_x),
      .lo_y         (lo_y),
      .hi_y         (hi_y),
      .flag_x       (flag_x_ff[DIV_STAGES-1]),
      .flag_y       (flag_y_ff[DIV_STAGES-1]),
      .contact      (rsp_contact),
      .contact_time (rsp_contact_time)
   );

   // A miss always reports time zero.
   a_miss_time_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_contact |-> rsp_contact_time == '0)
      else $error("miss reported with nonzero contact time");

   // A hit never reports a time beyond t = 1.
   a_hit_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_contact |-> rsp_contact_time <= (FRAC_BITS+1)'(TIME_ONE))
      else $error("contact time beyond one");

   // A stalled response keeps every stage frozen, so the beat behind it stays.
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> valid_ff == $past(valid_ff))
      else $error("pipeline moved during a stall");

   // A request beat taken now shows up in the first stage next cycle.
   a_entry_tracked: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid_ff[0])
      else $error("accepted beat lost at pipeline entry");

endmodule
